### hdl/brm_pkg.sv
package brm_pkg;

  localparam int DEF_MAX_THREADS   = 8;
  localparam int DEF_MAX_RESOURCES = 4;
  localparam int DEF_COUNT_WIDTH   = 8;

  // Row numbers travel between the modules at the widest thread count.
  localparam int THREAD_IDX_W = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_AVOID_ENABLE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_THREADS   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_RESOURCES = 2'd2;

  localparam logic [2:0] KIND_LOAD    = 3'd0;
  localparam logic [2:0] KIND_CLAIM   = 3'd1;
  localparam logic [2:0] KIND_REQUEST = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;
  localparam logic [2:0] KIND_DETECT  = 3'd5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_ERROR = 2'd1;
  localparam logic [1:0] STATUS_WAIT  = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] thread;
    logic [7:0] amount;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] deadlocked;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SWEEP,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_EXEC,
    DP_CLEAR_ROW,
    DP_SWEEP_ROW,
    DP_FINISH
  } dp_op_t;

  typedef enum logic [1:0] {
    NX_DONE,
    NX_CLEAR,
    NX_SWEEP
  } exec_next_t;

  typedef struct packed {
    dp_op_t                  op;
    logic                    respond;
    logic [THREAD_IDX_W-1:0] row;
  } dp_cmd_t;

  typedef struct packed {
    exec_next_t next;
    logic       row_hit;
    logic       row_last;
  } dp_status_t;

endpackage

### hdl/brm_ctrl.sv
module brm_ctrl #(
  parameter int MAX_THREADS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_last,
  input  brm_pkg::dp_status_t st,
  output logic                busy,
  output brm_pkg::dp_cmd_t    cmd
);
  import brm_pkg::*;

  localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

  ctrl_state_t   state_r, state_nxt;
  logic [TW-1:0] row_r, row_nxt;
  logic          prog_r, prog_nxt;
  logic          clear_last;

  assign clear_last = (row_r == TW'(MAX_THREADS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      prog_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      prog_r  <= prog_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    prog_nxt  = prog_r;
    case (state_r)
      ST_IDLE: begin
        if (start && in_last) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        row_nxt  = '0;
        prog_nxt = 1'b0;
        case (st.next)
          NX_CLEAR: state_nxt = ST_CLEAR;
          NX_SWEEP: state_nxt = ST_SWEEP;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_CLEAR: begin
        if (clear_last) state_nxt = ST_IDLE;
        else row_nxt = row_r + TW'(1);
      end
      ST_SWEEP: begin
        // A pass that freed any thread is followed by another full pass.
        if (st.row_last) begin
          row_nxt  = '0;
          prog_nxt = 1'b0;
          if (!(prog_r || st.row_hit)) state_nxt = ST_FINISH;
        end else begin
          row_nxt  = row_r + TW'(1);
          prog_nxt = prog_r || st.row_hit;
        end
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state_r != ST_IDLE);
    cmd.op      = DP_NONE;
    cmd.respond = 1'b0;
    cmd.row     = THREAD_IDX_W'(row_r);
    case (state_r)
      ST_IDLE: begin
        if (start) cmd.op = DP_CAPTURE;
      end
      ST_EXEC: begin
        cmd.op      = DP_EXEC;
        cmd.respond = (st.next == NX_DONE);
      end
      ST_CLEAR: begin
        cmd.op      = DP_CLEAR_ROW;
        cmd.respond = clear_last;
      end
      ST_SWEEP:  cmd.op = DP_SWEEP_ROW;
      ST_FINISH: begin
        cmd.op      = DP_FINISH;
        cmd.respond = 1'b1;
      end
      default: cmd.op = DP_NONE;
    endcase
  end

endmodule

### hdl/brm_datapath.sv
module brm_datapath #(
  parameter int MAX_THREADS   = 8,
  parameter int MAX_RESOURCES = 4,
  parameter int COUNT_WIDTH   = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  brm_pkg::in_item_t                  in_item,
  input  logic                               cfg_we,
  input  logic [brm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [brm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  brm_pkg::dp_cmd_t                   cmd,
  output brm_pkg::dp_status_t                st,
  output logic                               out_valid,
  output brm_pkg::out_item_t                 out_item
);
  import brm_pkg::*;

  localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int NW = $clog2(MAX_THREADS + 1);
  localparam int MW = $clog2(MAX_RESOURCES + 1);
  localparam int DW = $clog2(MAX_THREADS + 1);
  localparam int CW = COUNT_WIDTH;
  // Work vector holds available plus every allocation, with a sign bit.
  localparam int WW = CW + $clog2(MAX_THREADS + 2) + 1;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};
  localparam logic signed [WW-1:0] ZERO_W = '0;
  localparam logic signed [WW-1:0] NEED_MIN_X = {{(WW-CW){1'b1}}, {CW{1'b0}}};
  localparam logic signed [CW:0] NEED_MIN = {1'b1, {CW{1'b0}}};

  logic                  avoid_r;
  logic [3:0]            athr_r;
  logic [2:0]            ares_r;
  logic [2:0]            kind_r;
  logic [2:0]            thr_r;
  logic [RW-1:0]         pos_r;
  logic [CW-1:0]         buf_r   [MAX_RESOURCES];
  logic [CW-1:0]         exist_r [MAX_RESOURCES];
  logic [CW-1:0]         avail_r [MAX_RESOURCES];
  logic [CW-1:0]         alloc_r [MAX_THREADS][MAX_RESOURCES];
  logic signed [CW:0]    need_r  [MAX_THREADS][MAX_RESOURCES];
  logic [CW-1:0]         pend_r  [MAX_THREADS][MAX_RESOURCES];
  logic signed [WW-1:0]  work_r  [MAX_RESOURCES];
  logic [MAX_THREADS-1:0] done_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [NW-1:0]         n_use;
  logic [MW-1:0]         m_use;
  logic [MAX_RESOURCES-1:0] act;
  logic                  t_ok, det, is_t, fits, hit;
  logic [TW-1:0]         rs, t_idx;
  logic signed [WW-1:0]  buf_x   [MAX_RESOURCES];
  logic signed [WW-1:0]  need_x  [MAX_RESOURCES];
  logic signed [WW-1:0]  pend_x  [MAX_RESOURCES];
  logic signed [WW-1:0]  vterm   [MAX_RESOURCES];
  logic signed [WW-1:0]  lhs     [MAX_RESOURCES];
  logic signed [WW-1:0]  addv    [MAX_RESOURCES];
  logic signed [WW-1:0]  nd      [MAX_RESOURCES];
  logic [CW:0]           sum_al  [MAX_RESOURCES];
  logic [CW:0]           sum_rel [MAX_RESOURCES];
  logic [CW:0]           sum_end [MAX_RESOURCES];
  logic [CW-1:0]         g_alloc [MAX_RESOURCES];
  logic signed [CW:0]    g_need  [MAX_RESOURCES];
  logic [CW-1:0]         rel_av  [MAX_RESOURCES];
  logic [CW-1:0]         end_av  [MAX_RESOURCES];
  logic                  gt_exist, gt_need, gt_avail, gt_alloc;
  logic [MAX_THREADS-1:0] beyond, done_det;
  logic [DW-1:0]         dead_cnt;
  logic                  do_load, do_det_init, do_safe_init, do_claim, do_refuse;
  logic                  do_pend_set, do_grant, do_release, do_end;
  exec_next_t            nx;
  logic [1:0]            res_status;
  logic [DW-1:0]         res_dead;

  always_comb begin
    if (athr_r == 4'd0) n_use = NW'(1);
    else if (int'(athr_r) > MAX_THREADS) n_use = NW'(MAX_THREADS);
    else n_use = NW'(athr_r);
    if (ares_r == 3'd0) m_use = MW'(1);
    else if (int'(ares_r) > MAX_RESOURCES) m_use = MW'(MAX_RESOURCES);
    else m_use = MW'(ares_r);
  end

  assign t_ok  = (int'(thr_r) < int'(n_use));
  assign det   = (kind_r == KIND_DETECT);
  assign t_idx = TW'(thr_r);
  assign rs    = (cmd.op == DP_CLEAR_ROW || cmd.op == DP_SWEEP_ROW) ? cmd.row[TW-1:0] : t_idx;
  assign is_t  = (rs == t_idx);

  // Per-lane arithmetic on the selected row.
  always_comb begin
    fits     = 1'b1;
    gt_exist = 1'b0;
    gt_need  = 1'b0;
    gt_avail = 1'b0;
    gt_alloc = 1'b0;
    for (int j = 0; j < MAX_RESOURCES; j++) begin
      act[j]    = (j < int'(m_use));
      buf_x[j]  = $signed(WW'(buf_r[j]));
      need_x[j] = WW'(need_r[rs][j]);
      pend_x[j] = $signed(WW'(pend_r[rs][j]));
      vterm[j]  = (is_t && !det) ? buf_x[j] : ZERO_W;
      lhs[j]    = det ? pend_x[j] : (need_x[j] - vterm[j]);
      addv[j]   = $signed(WW'(alloc_r[rs][j])) + vterm[j];
      if (act[j] && (lhs[j] > work_r[j])) fits = 1'b0;
      if (act[j] && (buf_r[j] > exist_r[j])) gt_exist = 1'b1;
      if (act[j] && (buf_x[j] > need_x[j])) gt_need = 1'b1;
      if (act[j] && (buf_r[j] > avail_r[j])) gt_avail = 1'b1;
      if (act[j] && (buf_r[j] > alloc_r[rs][j])) gt_alloc = 1'b1;
      sum_al[j]  = {1'b0, alloc_r[rs][j]} + {1'b0, buf_r[j]};
      sum_rel[j] = {1'b0, avail_r[j]} + {1'b0, buf_r[j]};
      sum_end[j] = {1'b0, avail_r[j]} + {1'b0, alloc_r[rs][j]};
      g_alloc[j] = sum_al[j][CW] ? CMAX : sum_al[j][CW-1:0];
      rel_av[j]  = sum_rel[j][CW] ? CMAX : sum_rel[j][CW-1:0];
      end_av[j]  = sum_end[j][CW] ? CMAX : sum_end[j][CW-1:0];
      nd[j]      = need_x[j] - buf_x[j];
      g_need[j]  = (nd[j] < NEED_MIN_X) ? NEED_MIN : nd[j][CW:0];
    end
  end

  assign hit = (cmd.op == DP_SWEEP_ROW) && !done_r[rs] && fits;

  always_comb begin
    dead_cnt = '0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      beyond[i]   = (i >= int'(n_use));
      done_det[i] = 1'b1;
      for (int j = 0; j < MAX_RESOURCES; j++) begin
        if (act[j] && (pend_r[i][j] != '0)) done_det[i] = 1'b0;
      end
      done_det[i] = done_det[i] || beyond[i];
      dead_cnt    = dead_cnt + DW'(!done_r[i]);
    end
  end

  always_comb begin
    nx           = NX_DONE;
    res_status   = STATUS_OK;
    res_dead     = '0;
    do_load      = 1'b0;
    do_det_init  = 1'b0;
    do_safe_init = 1'b0;
    do_claim     = 1'b0;
    do_refuse    = 1'b0;
    do_pend_set  = 1'b0;
    do_grant     = 1'b0;
    do_release   = 1'b0;
    do_end       = 1'b0;
    case (cmd.op)
      DP_EXEC: begin
        if (kind_r > KIND_DETECT) begin
          res_status = STATUS_ERROR;
        end else if (kind_r == KIND_LOAD) begin
          nx      = NX_CLEAR;
          do_load = 1'b1;
        end else if (det) begin
          nx          = NX_SWEEP;
          do_det_init = 1'b1;
        end else if (!t_ok) begin
          res_status = STATUS_ERROR;
        end else begin
          case (kind_r)
            KIND_CLAIM: begin
              if (gt_exist) res_status = STATUS_ERROR;
              else do_claim = 1'b1;
            end
            KIND_REQUEST: begin
              if (gt_exist || (avoid_r && gt_need)) begin
                res_status = STATUS_ERROR;
                do_refuse  = 1'b1;
              end else if (gt_avail) begin
                res_status  = STATUS_WAIT;
                do_pend_set = 1'b1;
              end else if (avoid_r) begin
                nx           = NX_SWEEP;
                do_pend_set  = 1'b1;
                do_safe_init = 1'b1;
              end else begin
                do_grant = 1'b1;
              end
            end
            KIND_RELEASE: begin
              if (gt_alloc) res_status = STATUS_ERROR;
              else do_release = 1'b1;
            end
            KIND_END: do_end = 1'b1;
            default:  res_status = STATUS_ERROR;
          endcase
        end
      end
      DP_FINISH: begin
        if (det) res_dead = dead_cnt;
        else if (&done_r) do_grant = 1'b1;
        else res_status = STATUS_WAIT;
      end
      default: nx = NX_DONE;
    endcase
  end

  assign st.next     = nx;
  assign st.row_hit  = hit;
  assign st.row_last = (int'(rs) == int'(n_use) - 1);

  always_ff @(posedge clk) begin
    if (cmd.op == DP_CAPTURE) buf_r[pos_r] <= CW'(in_item.amount);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avoid_r     <= 1'b0;
      athr_r      <= 4'd8;
      ares_r      <= 3'd4;
      kind_r      <= '0;
      thr_r       <= '0;
      pos_r       <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
      for (int j = 0; j < MAX_RESOURCES; j++) begin
        exist_r[j] <= '0;
        avail_r[j] <= '0;
        work_r[j]  <= '0;
      end
      for (int i = 0; i < MAX_THREADS; i++) begin
        for (int j = 0; j < MAX_RESOURCES; j++) begin
          alloc_r[i][j] <= '0;
          need_r[i][j]  <= '0;
          pend_r[i][j]  <= '0;
        end
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AVOID_ENABLE:     avoid_r <= cfg_data[0];
          CFG_ACTIVE_THREADS:   athr_r  <= cfg_data[3:0];
          CFG_ACTIVE_RESOURCES: ares_r  <= cfg_data[2:0];
          default:              avoid_r <= avoid_r;
        endcase
      end

      out_valid_r <= cmd.respond;
      if (cmd.respond) begin
        out_r.status     <= res_status;
        out_r.deadlocked <= 4'(res_dead);
      end

      if (cmd.op == DP_CAPTURE) begin
        kind_r <= in_item.kind;
        thr_r  <= in_item.thread;
        if (in_item.last) pos_r <= '0;
        else if (pos_r != RW'(MAX_RESOURCES - 1)) pos_r <= pos_r + RW'(1);
      end

      if (do_det_init) done_r <= done_det;
      if (do_safe_init) done_r <= beyond;
      if (hit) done_r[rs] <= 1'b1;

      for (int j = 0; j < MAX_RESOURCES; j++) begin
        if (do_load) begin
          exist_r[j] <= act[j] ? buf_r[j] : '0;
          avail_r[j] <= act[j] ? buf_r[j] : '0;
        end
        if (do_det_init) work_r[j] <= $signed(WW'(avail_r[j]));
        if (do_safe_init) work_r[j] <= $signed(WW'(avail_r[j])) - buf_x[j];
        if (hit) work_r[j] <= work_r[j] + addv[j];
        if (cmd.op == DP_CLEAR_ROW) begin
          alloc_r[rs][j] <= '0;
          need_r[rs][j]  <= '0;
          pend_r[rs][j]  <= '0;
        end
        if (do_end) begin
          avail_r[j]     <= end_av[j];
          alloc_r[rs][j] <= '0;
          need_r[rs][j]  <= '0;
          pend_r[rs][j]  <= '0;
        end
        if (act[j]) begin
          if (do_claim) need_r[rs][j] <= $signed({1'b0, buf_r[j]});
          if (do_refuse) pend_r[rs][j] <= '0;
          if (do_pend_set) pend_r[rs][j] <= buf_r[j];
          if (do_release) begin
            avail_r[j]     <= rel_av[j];
            alloc_r[rs][j] <= alloc_r[rs][j] - buf_r[j];
          end
          if (do_grant) begin
            avail_r[j]     <= avail_r[j] - buf_r[j];
            alloc_r[rs][j] <= g_alloc[j];
            need_r[rs][j]  <= g_need[j];
            pend_r[rs][j]  <= '0;
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### hdl/bankers_resource_manager.sv
// Banker's resource manager. A command's vector arrives one count per item;
// an item without last is captured while idle and leaves busy low. The item
// marked last raises busy while the command runs, and its single result
// appears on out_valid/out_item for exactly one cycle when busy falls; the
// receiver cannot stall it. Claim, release, thread end, refused or waiting
// requests and requests without avoidance finish in the execute step. Load
// then clears every table row, one per cycle. Detection and an
// avoidance request that passes the simple checks run the row sweep: one
// thread row per cycle, passes over n = active_threads rows repeated until
// a pass frees nothing.
module bankers_resource_manager #(
  parameter int MAX_THREADS   = brm_pkg::DEF_MAX_THREADS,
  parameter int MAX_RESOURCES = brm_pkg::DEF_MAX_RESOURCES,
  parameter int COUNT_WIDTH   = brm_pkg::DEF_COUNT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  brm_pkg::in_item_t               in_item,
  output logic                            out_valid,
  output brm_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [brm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [brm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import brm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  brm_ctrl #(
    .MAX_THREADS(MAX_THREADS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_item.last),
    .st      (st),
    .busy    (busy),
    .cmd     (cmd)
  );

  brm_datapath #(
    .MAX_THREADS   (MAX_THREADS),
    .MAX_RESOURCES (MAX_RESOURCES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### hdl/brm_checker.sv
module brm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input brm_pkg::in_item_t               in_item,
  input logic                            out_valid,
  input brm_pkg::out_item_t              out_item,
  input logic                            cfg_we,
  input logic [brm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [brm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import brm_pkg::*;

  // A transfer that is not the last element never starts a command.
  a_mid_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_item.last |=> !busy && !out_valid)
    else $error("non-last element started a command");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.last |=> busy)
    else $error("last element did not start a command");

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result without a command finishing");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status == STATUS_OK || out_item.status == STATUS_ERROR ||
                  out_item.status == STATUS_WAIT)
    else $error("unknown status code");

  a_dead_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.deadlocked != 4'd0 |-> out_item.status == STATUS_OK)
    else $error("deadlock count with error status");

endmodule

bind bankers_resource_manager brm_checker u_brm_checker (.*);
